FILE: rtl/idm_pkg.sv
`default_nettype none
package idm_pkg;
  localparam int unsigned DATA_WIDTH = 64;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    FUNC_DIVU = 2'd0,
    FUNC_REMU = 2'd1,
    FUNC_DIV  = 2'd2,
    FUNC_REM  = 2'd3
  } func_e;

  // classified request handed from front to back
  typedef struct packed {
    logic                  is_rem;
    logic                  neg_res;
    logic                  zero;
    logic [DATA_WIDTH-1:0] num;
    logic [DATA_WIDTH-1:0] den;
  } op_t;
endpackage
`default_nettype wire

FILE: rtl/idm_req_if.sv
`default_nettype none
interface idm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] dividend;
  logic [63:0] divisor;
  modport source (output valid, func, dividend, divisor, input ready);
  modport sink (input valid, func, dividend, divisor, output ready);
endinterface
`default_nettype wire

FILE: rtl/idm_rsp_if.sv
`default_nettype none
interface idm_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic        div_by_zero;
  modport source (output valid, result, div_by_zero, input ready);
  modport sink (input valid, result, div_by_zero, output ready);
endinterface
`default_nettype wire

FILE: rtl/idm_front.sv
`default_nettype none
module idm_front (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  idm_req_if.sink         req,
  output idm_pkg::op_t    op_o,
  output logic            op_valid_o,
  input  wire logic       op_ready_i
);
  import idm_pkg::*;

  op_t  op_q, op_d;
  logic vld_q;
  logic sgn, a_neg, b_neg;
  logic [DATA_WIDTH-1:0] a, b;

  assign req.ready = !vld_q || op_ready_i;

  always_comb begin
    a = req.dividend[DATA_WIDTH-1:0];
    b = req.divisor[DATA_WIDTH-1:0];
    sgn = (req.func == FUNC_DIV) || (req.func == FUNC_REM);
    a_neg = sgn && a[DATA_WIDTH-1];
    b_neg = sgn && b[DATA_WIDTH-1];
    op_d.is_rem = (req.func == FUNC_REMU) || (req.func == FUNC_REM);
    op_d.neg_res = op_d.is_rem ? a_neg : (a_neg ^ b_neg);
    op_d.zero = (b == '0);
    op_d.num = a_neg ? (~a + 1'b1) : a;
    op_d.den = b_neg ? (~b + 1'b1) : b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (req.ready) begin
      vld_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.ready && req.valid) begin
      op_q <= op_d;
    end
  end

  assign op_o = op_q;
  assign op_valid_o = vld_q;
endmodule
`default_nettype wire

FILE: rtl/idm_fifo.sv
`default_nettype none
module idm_fifo (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  idm_pkg::op_t  in_i,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output idm_pkg::op_t  out_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i
);
  import idm_pkg::*;

  op_t mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;
  logic push, pop;

  assign in_ready_o  = (cnt_q != (PTR_W+1)'(FIFO_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign out_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PTR_W+1)'(FIFO_DEPTH)) else $error("fifo count overflow");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("fifo count slip");
  a_empty_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> wr_q == rd_q) else $error("fifo pointer mismatch");
endmodule
`default_nettype wire

FILE: rtl/idm_back.sv
`default_nettype none
module idm_back (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  idm_pkg::op_t  op_i,
  input  wire logic     op_valid_i,
  output logic          op_ready_o,
  idm_rsp_if.source     rsp
);
  import idm_pkg::*;

  localparam int unsigned NS = DATA_WIDTH + 1;
  localparam int unsigned W = DATA_WIDTH;

  // stage s holds partial remainder after s quotient bits; quotient bits
  // shift into the low end of num as dividend bits leave the top
  logic         vld_q  [NS];
  logic         rem_q  [NS];
  logic         neg_q  [NS];
  logic         zero_q [NS];
  logic [W-1:0] num_q  [NS];
  logic [W-1:0] den_q  [NS];
  logic [W-1:0] part_q [NS];
  logic         adv    [NS];
  logic [W-1:0] res;

  // stage NS-1 is the output register, stall propagates back
  assign adv[NS-1] = !vld_q[NS-1] || rsp.ready;
  for (genvar s = NS-2; s >= 0; s--) begin : g_adv
    assign adv[s] = !vld_q[s] || adv[s+1];
  end
  assign op_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv[0]) begin
      vld_q[0] <= op_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && op_valid_i) begin
      rem_q[0]  <= op_i.is_rem;
      neg_q[0]  <= op_i.neg_res;
      zero_q[0] <= op_i.zero;
      num_q[0]  <= op_i.num;
      den_q[0]  <= op_i.den;
      part_q[0] <= '0;
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_stage
    logic         carry;
    logic [W-1:0] sh;
    logic         ge;
    assign carry = part_q[s-1][W-1];
    assign sh = {part_q[s-1][W-2:0], num_q[s-1][W-1]};
    assign ge = carry || (sh >= den_q[s-1]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv[s]) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[s] && vld_q[s-1]) begin
        rem_q[s]  <= rem_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        zero_q[s] <= zero_q[s-1];
        den_q[s]  <= den_q[s-1];
        part_q[s] <= ge ? (sh - den_q[s-1]) : sh;
        num_q[s]  <= {num_q[s-1][W-2:0], ge};
      end
    end
  end

  always_comb begin
    res = rem_q[NS-1] ? part_q[NS-1] : num_q[NS-1];
    if (neg_q[NS-1]) res = ~res + 1'b1;
    if (zero_q[NS-1]) res = '0;
  end

  assign rsp.valid = vld_q[NS-1];
  assign rsp.result = 64'(res);
  assign rsp.div_by_zero = zero_q[NS-1];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result))
    else $error("result changed under stall");
  a_part_lt_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS-1] && !zero_q[NS-1] |-> part_q[NS-1] < den_q[NS-1])
    else $error("remainder not below divisor");
  a_zero_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.div_by_zero |-> rsp.result == '0)
    else $error("zero divisor result not cleared");
endmodule
`default_nettype wire

FILE: rtl/int64_divide_modulo.sv
// int64_divide_modulo: 64-bit integer divide and remainder
// request channel (req): func, dividend, divisor; func selects unsigned
//   quotient, unsigned remainder, signed quotient (toward zero) or signed
//   remainder (sign of dividend)
// response channel (rsp): result and div_by_zero; a zero divisor gives
//   result 0 with div_by_zero set
// the front stage takes signs and magnitudes and registers the request,
// a four-entry queue decouples it from the back end
// the back end is a restoring divider: an input register followed by
// 64 stages of one quotient bit each, the last stage drives the response
// throughput: one request per cycle while rsp.ready stays high;
//   a request passes the front register, queue, back input register and
//   the 64 divide stages
// receiver stall: the divide pipeline holds, then the queue fills, then
//   req.ready drops; nothing is lost or repeated
// reset: all valid bits and queue pointers clear, no request in flight
`default_nettype none
module int64_divide_modulo (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  idm_req_if.sink   req,
  idm_rsp_if.source rsp
);
  import idm_pkg::*;

  op_t  f_op, q_op;
  logic f_vld, f_rdy, q_vld, q_rdy;

  // front: classify and take magnitudes
  idm_front u_front (
    .clk_i, .rst_ni, .req,
    .op_o(f_op), .op_valid_o(f_vld), .op_ready_i(f_rdy)
  );

  // decoupling queue
  idm_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_i(f_op), .in_valid_i(f_vld), .in_ready_o(f_rdy),
    .out_o(q_op), .out_valid_o(q_vld), .out_ready_i(q_rdy)
  );

  // back: pipelined restoring divide and sign fixup
  idm_back u_back (
    .clk_i, .rst_ni,
    .op_i(q_op), .op_valid_i(q_vld), .op_ready_o(q_rdy), .rsp
  );
endmodule
`default_nettype wire

FILE: tb/tb_idm_scoreboard.sv
`timescale 1ns / 1ps
package tb_idm_scoreboard_pkg;
  import idm_pkg::*;

  typedef struct {
    logic [63:0] result;
    logic        div_by_zero;
  } quot_rem_t;

  class quot_rem_scoreboard;
    quot_rem_t pending_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // restoring division of magnitudes, msb first, keeping the carry bit
    function automatic logic [63:0] restore_divide(logic [63:0] num, logic [63:0] den,
                                                   output logic [63:0] rem);
      logic [63:0] quo;
      logic [63:0] part;
      logic        carry;
      quo  = '0;
      part = '0;
      for (int b = 63; b >= 0; b--) begin
        carry = part[63];
        part  = {part[62:0], num[b]};
        if (carry || part >= den) begin
          part   = part - den;
          quo[b] = 1'b1;
        end
      end
      rem = part;
      return quo;
    endfunction

    function void note_request(func_e fn, logic [63:0] a, logic [63:0] b);
      quot_rem_t   exp_item;
      logic        a_neg;
      logic        b_neg;
      logic [63:0] quo;
      logic [63:0] rem;
      a_neg = 1'b0;
      b_neg = 1'b0;
      if (b == '0) begin
        exp_item.result      = '0;
        exp_item.div_by_zero = 1'b1;
      end else begin
        if (fn == FUNC_DIV || fn == FUNC_REM) begin
          a_neg = a[63];
          b_neg = b[63];
          if (a_neg) a = -a;
          if (b_neg) b = -b;
        end
        quo = restore_divide(a, b, rem);
        case (fn)
          FUNC_DIVU: exp_item.result = quo;
          FUNC_REMU: exp_item.result = rem;
          FUNC_DIV:  exp_item.result = (a_neg != b_neg) ? -quo : quo;
          default:   exp_item.result = a_neg ? -rem : rem;
        endcase
        exp_item.div_by_zero = 1'b0;
      end
      pending_q.push_back(exp_item);
    endfunction

    function void check_response(logic [63:0] result, logic div_by_zero);
      quot_rem_t exp_item;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response result=%h dbz=%b", result, div_by_zero);
        return;
      end
      exp_item = pending_q.pop_front();
      if (result !== exp_item.result || div_by_zero !== exp_item.div_by_zero) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected result=%h dbz=%b, got result=%h dbz=%b",
                   exp_item.result, exp_item.div_by_zero, result, div_by_zero);
      end
    endfunction
  endclass
endpackage

FILE: tb/tb_int64_divide_modulo.sv
`timescale 1ns / 1ps
module tb_int64_divide_modulo;
  import idm_pkg::*;
  import tb_idm_scoreboard_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 100;
  // pipeline latency plus worst receiver stalls, taken several times over
  localparam int unsigned STALL_LIMIT  = 5000;

  logic clk_i;
  logic rst_ni;

  idm_req_if req ();
  idm_rsp_if rsp ();

  int64_divide_modulo dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req.sink),
    .rsp    (rsp.source)
  );

  quot_rem_scoreboard sb = new();

  // idle rates in percent for the two sides
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned idle_cycles = 0;
  bit          stim_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // note requests and check responses at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req.valid && req.ready)
        sb.note_request(func_e'(req.func), req.dividend, req.divisor);
      if (rsp.valid && rsp.ready)
        sb.check_response(rsp.result, rsp.div_by_zero);
    end
  end

  // receiver back pressure, changed at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // hold one request until accepted; random idle gaps before it
  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(func_e fn, logic [63:0] a, logic [63:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid    <= 1'b1;
    req.func     <= fn;
    req.dividend <= a;
    req.divisor  <= b;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // random operand: often full random, else small, small negative, a power of two or shifted random
  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    case ($urandom_range(5))
      0: v = 64'($urandom_range(16));
      1: v = -64'($urandom_range(16));
      2: v = 64'h1 << $urandom_range(63);
      3: v = {$urandom, $urandom} >> $urandom_range(63);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic random_phase(int unsigned count);
    logic [63:0] b;
    repeat (count) begin
      b = pick_operand();
      if ($urandom_range(31) == 0) b = '0;
      send_request(func_e'($urandom_range(3)), pick_operand(), b);
    end
  endtask

  // pause until every expected response has arrived
  task automatic wait_drained();
    req.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  localparam logic [63:0] MIN_S = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_S = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] ALL1  = 64'hffff_ffff_ffff_ffff;

  initial begin
    rst_ni       = 1'b0;
    req.valid    = 1'b0;
    req.func     = FUNC_DIVU;
    req.dividend = '0;
    req.divisor  = '0;
    stim_done    = 1'b0;
    src_idle_pct = 8;
    snk_idle_pct = 82;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero divisor for every func, signed overflow, extremes
    for (int f = 0; f < 4; f++) begin
      send_request(func_e'(f), 64'd12345, '0);
      send_request(func_e'(f), MIN_S, ALL1);
      send_request(func_e'(f), ALL1, MIN_S);
      send_request(func_e'(f), -64'sd7, 64'd2);
    end
    send_request(FUNC_DIVU, ALL1, 64'd1);
    send_request(FUNC_REMU, ALL1, 64'hffff_ffff_ffff_fffe);
    send_request(FUNC_DIV, MAX_S, -64'sd1);
    send_request(FUNC_REM, MIN_S, 64'd3);
    send_request(FUNC_DIVU, '0, ALL1);
    send_request(FUNC_DIV, 64'd7, -64'sd2);
    send_request(FUNC_REM, 64'd7, -64'sd2);

    random_phase(160);
    wait_drained();
    src_idle_pct = 82;
    snk_idle_pct = 8;
    random_phase(160);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_phase(160);

    // drain, then let the pipe settle
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
